@@ src/ptw_pkg.sv @@
// Shared constants, types and codes of the four-level page-table walker.
package ptw_pkg;

    localparam int unsigned STORE_WORDS = 4096;
    localparam int unsigned STORE_AW    = $clog2(STORE_WORDS);

    localparam int unsigned VA_W   = 48;
    localparam int unsigned PA_W   = 52;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned IDX_W  = 9;
    // Word index of an entry: 40-bit table frame number followed by a 9-bit index.
    localparam int unsigned WIDX_W = PA_W - 12 + IDX_W;

    localparam int unsigned PRESENT_BIT = 0;
    localparam int unsigned LARGE_BIT   = 7;

    typedef enum logic [2:0] {
        ST_WRITTEN    = 3'd0,
        ST_MAP4K      = 3'd1,
        ST_MAP2M      = 3'd2,
        ST_MAP1G      = 3'd3,
        ST_NOTPRESENT = 3'd4,
        ST_OUTSIDE    = 3'd5
    } t_status;

    typedef enum logic {
        OP_WRITE     = 1'b0,
        OP_TRANSLATE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [STORE_AW-1:0] addr;
        logic [WORD_W-1:0]   wdata;
    } t_mem_req;

    typedef struct packed {
        t_status         status;
        logic [PA_W-1:0] phys_addr;
    } t_result;

endpackage

@@ src/ptw_store.sv @@
// Single-port table store with a registered read port.
module ptw_store (
    input  logic                        i_clk,
    input  ptw_pkg::t_mem_req           i_req,
    output logic [ptw_pkg::WORD_W-1:0]  o_rdata
);

    logic [ptw_pkg::WORD_W-1:0] r_mem [ptw_pkg::STORE_WORDS];
    logic [ptw_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/ptw_walker.sv @@
// Walk sequencer: table writes, level-by-level entry reads and result forming.
module ptw_walker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  ptw_pkg::t_opcode             i_opcode,
    input  logic [ptw_pkg::VA_W-1:0]     i_address,
    input  logic [ptw_pkg::WORD_W-1:0]   i_entry_data,
    input  logic [ptw_pkg::PA_W-13:0]    i_root_frame,
    output ptw_pkg::t_mem_req            o_mem_req,
    input  logic [ptw_pkg::WORD_W-1:0]   i_mem_rdata,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output ptw_pkg::t_result             o_res
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WAIT   = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [1:0]                  r_level, n_level;
    logic [ptw_pkg::VA_W-1:0]    r_va, n_va;
    ptw_pkg::t_result            r_res, n_res;

    logic                        accept;
    logic [ptw_pkg::IDX_W-1:0]   next_idx;
    logic [ptw_pkg::WIDX_W-1:0]  root_w;
    logic [ptw_pkg::WIDX_W-1:0]  next_w;
    logic [ptw_pkg::VA_W-4:0]    wr_w;
    logic [ptw_pkg::WORD_W-1:0]  e;

    assign accept      = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;
    assign e           = i_mem_rdata;

    // Index of the level below the current one.
    always_comb begin
        case (r_level)
            2'd3:    next_idx = r_va[38:30];
            2'd2:    next_idx = r_va[29:21];
            default: next_idx = r_va[20:12];
        endcase
    end

    assign root_w = {i_root_frame, i_address[47:39]};
    assign next_w = {e[ptw_pkg::PA_W-1:12], next_idx};
    assign wr_w   = i_address[ptw_pkg::VA_W-1:3];

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_va      = r_va;
        n_res     = r_res;
        o_mem_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_va            = i_address;
                    n_res.phys_addr = '0;
                    if (i_opcode == ptw_pkg::OP_WRITE) begin
                        n_state = S_RESULT;
                        if (wr_w < (ptw_pkg::VA_W-3)'(ptw_pkg::STORE_WORDS)) begin
                            o_mem_req.we    = 1'b1;
                            o_mem_req.addr  = wr_w[ptw_pkg::STORE_AW-1:0];
                            o_mem_req.wdata = i_entry_data;
                            n_res.status    = ptw_pkg::ST_WRITTEN;
                        end else begin
                            n_res.status = ptw_pkg::ST_OUTSIDE;
                        end
                    end else if (root_w < ptw_pkg::WIDX_W'(ptw_pkg::STORE_WORDS)) begin
                        o_mem_req.re   = 1'b1;
                        o_mem_req.addr = root_w[ptw_pkg::STORE_AW-1:0];
                        n_level        = 2'd3;
                        n_state        = S_WAIT;
                    end else begin
                        n_res.status = ptw_pkg::ST_OUTSIDE;
                        n_state      = S_RESULT;
                    end
                end
            end
            S_WAIT: begin
                n_state = S_RESULT;
                if (!e[ptw_pkg::PRESENT_BIT]) begin
                    n_res.status = ptw_pkg::ST_NOTPRESENT;
                end else if (r_level == 2'd2 && e[ptw_pkg::LARGE_BIT]) begin
                    n_res.status    = ptw_pkg::ST_MAP1G;
                    n_res.phys_addr = {e[ptw_pkg::PA_W-1:30], r_va[29:0]};
                end else if (r_level == 2'd1 && e[ptw_pkg::LARGE_BIT]) begin
                    n_res.status    = ptw_pkg::ST_MAP2M;
                    n_res.phys_addr = {e[ptw_pkg::PA_W-1:21], r_va[20:0]};
                end else if (r_level == 2'd0) begin
                    n_res.status    = ptw_pkg::ST_MAP4K;
                    n_res.phys_addr = {e[ptw_pkg::PA_W-1:12], r_va[11:0]};
                end else if (next_w < ptw_pkg::WIDX_W'(ptw_pkg::STORE_WORDS)) begin
                    // descend one level
                    o_mem_req.re   = 1'b1;
                    o_mem_req.addr = next_w[ptw_pkg::STORE_AW-1:0];
                    n_level        = r_level - 2'd1;
                    n_state        = S_WAIT;
                end else begin
                    n_res.status = ptw_pkg::ST_OUTSIDE;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_level <= n_level;
        r_va    <= n_va;
        r_res   <= n_res;
    end

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.we && o_mem_req.re))
        else $error("store read and write issued together");

    a_read_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.re |=> r_state == S_WAIT)
        else $error("entry read not followed by wait state");

    a_level_descends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && o_mem_req.re) |=> r_level == $past(r_level) - 2'd1)
        else $error("walk level did not descend");

    a_fault_pa_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (r_res.status == ptw_pkg::ST_WRITTEN
            || r_res.status == ptw_pkg::ST_NOTPRESENT
            || r_res.status == ptw_pkg::ST_OUTSIDE)) |-> r_res.phys_addr == '0)
        else $error("non-mapped result carries an address");

endmodule

@@ src/four_level_page_table_walker_core.sv @@
// A table write goes through the walker's result state and then the output register; a translation
// does one store read per level walked, then the result state and then the output register.
// Items are handled one at a time: a new request is taken only once the walker is idle again,
// after its last result has moved into the output register, which m_axis_tready can hold.
// Reset (synchronous, active low) clears table_root and the control state;
// the table store is not cleared and must be written before it is walked.
module four_level_page_table_walker_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,  // address[47:0], entry_data[111:48]
    input  logic [0:0]    s_axis_tuser,  // opcode[0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [55:0]   m_axis_tdata,  // phys_addr[51:0], zero pad[55:52]
    output logic [2:0]    m_axis_tuser,  // status[2:0]
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [51:0]   i_cfg_data     // table_root[51:0]
);

    logic [ptw_pkg::PA_W-1:0]   r_root;
    logic                       r_out_valid;
    ptw_pkg::t_result           r_out;

    ptw_pkg::t_mem_req          mem_req;
    logic [ptw_pkg::WORD_W-1:0] mem_rdata;
    logic                       res_valid;
    logic                       res_ready;
    ptw_pkg::t_result           res;

    assign o_cfg_ready = 1'b1;
    // Output register takes a new result when empty or draining this cycle.
    assign res_ready   = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_root <= i_cfg_data;
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    ptw_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    ptw_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_opcode     (ptw_pkg::t_opcode'(s_axis_tuser[0])),
        .i_address    (s_axis_tdata[47:0]),
        .i_entry_data (s_axis_tdata[111:48]),
        .i_root_frame (r_root[ptw_pkg::PA_W-1:12]),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.phys_addr};
    assign m_axis_tuser  = r_out.status;

endmodule
